@@ hdl/cvs_pkg.sv @@
// Shared types and constants of the capacity vario vertical speed unit.
`timescale 1ns / 1ps

package cvs_pkg;

    // Shared divider: dividend and divisor widths
    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 56;

    // Shared wide multiplier: operand width, built from half-width partial products
    localparam int MUL_W = 64;
    localparam int MUL_H = MUL_W / 2;

    // Configuration register indexes
    localparam logic CFG_CAPACITY = 1'b0;
    localparam logic CFG_GAIN     = 1'b1;

    typedef enum logic [1:0] {
        DIV_SEL_K    = 2'd0,
        DIV_SEL_RATE = 2'd1,
        DIV_SEL_V    = 2'd2
    } div_sel_t;

    typedef enum logic {
        MUL_SEL_X    = 1'b0,
        MUL_SEL_STEP = 1'b1
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     rom_sel;
        logic     ld_p0;
        logic     ld_ps;
        logic     div_start;
        div_sel_t div_sel;
        logic     ld_k;
        logic     ld_q;
        logic     ld_pte;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     ld_rate;
        logic     ld_x;
        logic     ld_step;
        logic     ld_pc;
        logic     res_prev;
        logic     seed;
        logic     commit;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic mul_done;
        logic tick_eq;
        logic unseeded;
    } stat_t;

endpackage

@@ hdl/cvs_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module cvs_div
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [cvs_pkg::DIV_NUM_W-1:0]  num,
    input  logic [cvs_pkg::DIV_DEN_W-1:0]  den,
    output logic                           done,
    output logic [cvs_pkg::DIV_NUM_W-1:0]  quo
);

    localparam int NW = cvs_pkg::DIV_NUM_W;
    localparam int DW = cvs_pkg::DIV_DEN_W;
    localparam int CW = $clog2(NW);

    logic [NW-1:0] quo_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [DW:0]   rem_sh;
    logic [DW:0]   diff;
    logic          ge;

    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[NW-1]};
        diff   = rem_sh - {1'b0, den_reg};
        ge     = rem_sh >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
            quo_reg <= {quo_reg[NW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

@@ hdl/cvs_mul.sv @@
// Wide multiplier: four half-width partial products, one per cycle, accumulated.
`timescale 1ns / 1ps

module cvs_mul
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [cvs_pkg::MUL_W-1:0]     a,
    input  logic [cvs_pkg::MUL_W-1:0]     b,
    output logic                          done,
    output logic [2*cvs_pkg::MUL_W-1:0]   prod
);

    localparam int W = cvs_pkg::MUL_W;
    localparam int H = cvs_pkg::MUL_H;

    logic [W-1:0]   a_reg;
    logic [W-1:0]   b_reg;
    logic [1:0]     cnt_reg;
    logic           issue_reg;
    logic [W-1:0]   pp_reg;
    logic [1:0]     pp_sh_reg;
    logic           pp_v_reg;
    logic           pp_last_reg;
    logic [2*W-1:0] acc_reg;
    logic           done_reg;

    logic [H-1:0]   a_part;
    logic [H-1:0]   b_part;
    logic [2*W-1:0] pp_ext;

    always_comb
    begin
        a_part = cnt_reg[1] ? a_reg[W-1:H] : a_reg[H-1:0];
        b_part = cnt_reg[0] ? b_reg[W-1:H] : b_reg[H-1:0];
        case (pp_sh_reg)
            2'd0:    pp_ext = {{W{1'b0}}, pp_reg};
            2'd1:    pp_ext = {{H{1'b0}}, pp_reg, {H{1'b0}}};
            2'd2:    pp_ext = {pp_reg, {W{1'b0}}};
            default: pp_ext = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg   <= 1'b0;
            cnt_reg     <= '0;
            pp_v_reg    <= 1'b0;
            pp_last_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= pp_v_reg && pp_last_reg;
            pp_v_reg <= issue_reg;
            pp_last_reg <= issue_reg && (cnt_reg == 2'd3);
            if (start)
            begin
                issue_reg <= 1'b1;
                cnt_reg   <= '0;
            end
            else if (issue_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    issue_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (pp_v_reg)
        begin
            acc_reg <= acc_reg + pp_ext;
        end
        pp_reg    <= a_part * b_part;
        pp_sh_reg <= {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

@@ hdl/cvs_datapath.sv @@
// Datapath: atmosphere ROM, interpolation, capillary flow and rate arithmetic.
`timescale 1ns / 1ps

module cvs_datapath
#(
    parameter int TABLE_POINTS = 1025,
    parameter int TICK_WIDTH   = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [15:0]           cfg_data,
    input  logic [13:0]           height_m,
    input  logic [10:0]           airspeed,
    input  logic [TICK_WIDTH-1:0] tick_ms,
    input  cvs_pkg::cmd_t         cmd,
    output cvs_pkg::stat_t        stat,
    output logic signed [15:0]    vertical_speed
);

    localparam int AW    = $clog2(TABLE_POINTS);
    localparam int IDX_W = ((AW > 10) ? AW : 10) + 1;
    localparam int NW    = cvs_pkg::DIV_NUM_W;
    localparam int DW    = cvs_pkg::DIV_DEN_W;
    localparam int MW    = cvs_pkg::MUL_W;

    localparam logic [19:0] TQ_BASE   = 20'd576300;
    localparam logic [30:0] PC_MAX    = 31'h7FFF_FFFF;
    localparam logic [63:0] STEP_CAP  = 64'h1_0000_0000;
    localparam longint unsigned Q30   = 64'd1 << 30;

    // term / n for the series, n a small literal
    function automatic longint unsigned div_small(input longint unsigned v, input int n);
        longint unsigned r;
        begin
            case (n)
                1:  r = v / 1;
                2:  r = v / 2;
                3:  r = v / 3;
                4:  r = v / 4;
                5:  r = v / 5;
                6:  r = v / 6;
                7:  r = v / 7;
                8:  r = v / 8;
                9:  r = v / 9;
                10: r = v / 10;
                11: r = v / 11;
                12: r = v / 12;
                13: r = v / 13;
                14: r = v / 14;
                15: r = v / 15;
                16: r = v / 16;
                17: r = v / 17;
                18: r = v / 18;
                19: r = v / 19;
                20: r = v / 20;
                default: r = v;
            endcase
            return r;
        end
    endfunction

    // Standard-atmosphere pressure at 16*i metres, Q17.14 Pa
    function automatic logic [30:0] atm_entry(input int idx);
        longint          num;
        longint unsigned y;
        longint unsigned frac;
        longint unsigned kk;
        longint unsigned m;
        longint unsigned e;
        longint unsigned n;
        longint unsigned f;
        longint unsigned t;
        longint unsigned v;
        longint unsigned tu;
        longint          sum;
        longint          term;
        begin
            num = 64'sd576300 - 64'sd208 * longint'(idx);
            if (num <= 0)
                return '0;
            y  = (unsigned'(num) << 30) / 64'd576300;
            kk = 0;
            for (int j = 0; j < 16; j++)
            begin
                if (y < Q30)
                begin
                    y  = y << 1;
                    kk = kk + 1;
                end
            end
            frac = 0;
            for (int b = 1; b <= 30; b++)
            begin
                y = (y * y) >> 30;
                if (y >= (Q30 << 1))
                begin
                    y    = y >> 1;
                    frac = frac | (64'd1 << (30 - b));
                end
            end
            m = (kk << 30) - frac;
            e = (m * 64'd5511420) >> 20;
            n = e >> 30;
            f = e & (Q30 - 1);
            t = (f * 64'd744261118) >> 30;
            sum  = signed'(Q30);
            term = signed'(Q30);
            for (int b = 1; b <= 20; b++)
            begin
                tu   = (unsigned'(term) * t) >> 30;
                term = signed'(div_small(tu, b));
                if (b % 2 == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            if (sum < 0)
                sum = 0;
            v = ((64'd101325 << 14) * unsigned'(sum)) >> 30;
            if (n >= 63)
                return '0;
            return 31'(v >> n);
        end
    endfunction

    typedef logic [30:0] atm_tab_t [TABLE_POINTS];

    function automatic atm_tab_t build_atm();
        atm_tab_t tab;
        begin
            for (int i = 0; i < TABLE_POINTS; i++)
                tab[i] = atm_entry(i);
            return tab;
        end
    endfunction

    localparam atm_tab_t ATM = build_atm();

    // configuration and architectural state
    logic [11:0]           cap_reg;
    logic [15:0]           gain_reg;
    logic [TICK_WIDTH-1:0] last_tick_reg;
    logic [30:0]           bottle_reg;
    logic signed [15:0]    prev_reg;

    // payload pipeline
    logic [13:0]           h_reg;
    logic [10:0]           a_reg;
    logic [TICK_WIDTH-1:0] tick_reg;
    logic [30:0]           rom_q_reg;
    logic [30:0]           p0_reg;
    logic [30:0]           ps_reg;
    logic [21:0]           a2_reg;
    logic [19:0]           tq_reg;
    logic [33:0]           a2t_reg;
    logic [37:0]           denk_reg;
    logic [22:0]           k_reg;
    logic [29:0]           q_reg;
    logic [30:0]           pte_reg;
    logic [46:0]           rnum_reg;
    logic [19:0]           rden_reg;
    logic [TICK_WIDTH-1:0] dt_reg;
    logic [31:0]           mag_reg;
    logic                  dneg_reg;
    logic [39:0]           rate_reg;
    logic [63:0]           x_reg;
    logic [32:0]           step_reg;
    logic [30:0]           pc_new_reg;
    logic signed [31:0]    dp_reg;
    logic [41:0]           vnum_reg;
    logic [53:0]           vden_reg;
    logic signed [15:0]    res_reg;
    logic signed [15:0]    vertical_speed_reg;

    logic [IDX_W-1:0]      idx_ext;
    logic                  idx_last;
    logic [AW-1:0]         rom_addr;
    logic signed [31:0]    ip_d;
    logic signed [36:0]    ip_prod;
    logic signed [36:0]    ip_adj;
    logic signed [36:0]    ip_q;
    logic [31:0]           ps32;
    logic [53:0]           pk_prod;
    logic [11:0]           cap_eff;
    logic [32:0]           d_calc;
    logic [63:0]           dt64;
    logic                  dt_big;
    logic [63:0]           step_raw;
    logic signed [34:0]    pc_sum;
    logic [30:0]           pc_clamp;
    logic [30:0]           dp_mag;
    logic [14:0]           q_sat;
    logic signed [15:0]    v_calc;

    logic                  div_done;
    logic [NW-1:0]         div_quo;
    logic [NW-1:0]         div_num;
    logic [DW-1:0]         div_den;
    logic                  mul_done;
    logic [2*MW-1:0]       mul_prod;
    logic [MW-1:0]         mul_a;
    logic [MW-1:0]         mul_b;

    always_comb
    begin
        idx_ext  = IDX_W'(h_reg[13:4]);
        idx_last = (idx_ext + 1'b1) >= IDX_W'(TABLE_POINTS);
        if (idx_last)
            rom_addr = AW'(TABLE_POINTS - 1);
        else if (cmd.rom_sel)
            rom_addr = AW'(idx_ext + 1'b1);
        else
            rom_addr = AW'(idx_ext);

        // interpolation, quotient truncated toward zero
        ip_d    = $signed({1'b0, rom_q_reg}) - $signed({1'b0, p0_reg});
        ip_prod = ip_d * $signed({1'b0, h_reg[3:0]});
        ip_adj  = ip_prod + (ip_prod[36] ? 37'sd15 : 37'sd0);
        ip_q    = ip_adj >>> 4;
        ps32    = {1'b0, p0_reg} + ip_q[31:0];

        pk_prod = 54'(ps_reg) * 54'(k_reg);
        cap_eff = (cap_reg == '0) ? 12'd1 : cap_reg;
        d_calc  = {2'b00, pte_reg} - {2'b00, bottle_reg};
        dt64    = 64'(dt_reg);
        dt_big  = |dt64[63:44];

        step_raw = mul_prod[95:32];

        pc_sum = dneg_reg ? $signed({4'b0, bottle_reg} - {2'b0, step_reg})
                          : $signed({4'b0, bottle_reg} + {2'b0, step_reg});
        if (pc_sum[34])
            pc_clamp = '0;
        else if (pc_sum > $signed({4'b0, PC_MAX}))
            pc_clamp = PC_MAX;
        else
            pc_clamp = pc_sum[30:0];

        dp_mag = dp_reg[31] ? 31'(-dp_reg) : dp_reg[30:0];
        q_sat  = (|div_quo[NW-1:15]) ? 15'h7FFF : div_quo[14:0];
        if (dt_big)
            v_calc = '0;
        else if (!dp_reg[31] && dp_reg != '0)
            v_calc = -$signed({1'b0, q_sat});
        else
            v_calc = $signed({1'b0, q_sat});

        case (cmd.div_sel)
            cvs_pkg::DIV_SEL_K:
            begin
                div_num = {6'b0, a2t_reg, 24'b0};
                div_den = DW'(denk_reg);
            end
            cvs_pkg::DIV_SEL_RATE:
            begin
                div_num = NW'(rnum_reg);
                div_den = DW'(rden_reg);
            end
            cvs_pkg::DIV_SEL_V:
            begin
                div_num = NW'(vnum_reg);
                div_den = DW'(vden_reg);
            end
            default:
            begin
                div_num = '0;
                div_den = '1;
            end
        endcase

        if (cmd.mul_sel == cvs_pkg::MUL_SEL_X)
        begin
            mul_a = dt64;
            mul_b = MW'(rate_reg);
        end
        else
        begin
            mul_a = MW'(mag_reg);
            mul_b = x_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rom_q_reg <= ATM[rom_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= 12'd450;
            gain_reg      <= 16'd328;
            last_tick_reg <= '0;
            bottle_reg    <= '0;
            prev_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    cvs_pkg::CFG_CAPACITY: cap_reg  <= cfg_data[11:0];
                    cvs_pkg::CFG_GAIN:     gain_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.seed)
            begin
                bottle_reg    <= pte_reg;
                last_tick_reg <= tick_reg;
                prev_reg      <= '0;
            end
            else if (cmd.commit)
            begin
                bottle_reg    <= pc_new_reg;
                last_tick_reg <= tick_reg;
                prev_reg      <= v_calc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            h_reg    <= height_m;
            a_reg    <= airspeed;
            tick_reg <= tick_ms;
        end
        a2_reg   <= 22'(a_reg) * 22'(a_reg);
        tq_reg   <= TQ_BASE - 20'(18'(h_reg) * 18'd13);
        a2t_reg  <= 34'(a2_reg) * 34'd3125;
        denk_reg <= 38'(tq_reg) * 38'd229632;
        rnum_reg <= 47'(gain_reg) * 47'(pte_reg);
        rden_reg <= 20'(cap_eff) * 20'd250;
        dt_reg   <= tick_reg - last_tick_reg;
        dneg_reg <= d_calc[32];
        mag_reg  <= d_calc[32] ? 32'(-d_calc) : d_calc[31:0];
        vnum_reg <= 42'(dp_mag) * 42'd1143;
        vden_reg <= 54'(dt64[43:0]) * 54'd800;

        if (cmd.ld_p0)
            p0_reg <= rom_q_reg;
        if (cmd.ld_ps)
            ps_reg <= ps32[30:0];
        if (cmd.ld_k)
            k_reg <= div_quo[22:0];
        if (cmd.ld_q)
            q_reg <= pk_prod[53:24];
        if (cmd.ld_pte)
            pte_reg <= (ps_reg > {1'b0, q_reg}) ? ps_reg - {1'b0, q_reg} : '0;
        if (cmd.ld_rate)
            rate_reg <= div_quo[39:0];
        if (cmd.ld_x)
            x_reg <= (|mul_prod[127:64]) ? '1 : mul_prod[63:0];
        if (cmd.ld_step)
            step_reg <= (step_raw > STEP_CAP) ? STEP_CAP[32:0] : step_raw[32:0];
        if (cmd.ld_pc)
        begin
            pc_new_reg <= pc_clamp;
            dp_reg     <= $signed({1'b0, pc_clamp}) - $signed({1'b0, bottle_reg});
        end
        if (cmd.res_prev)
            res_reg <= prev_reg;
        else if (cmd.seed)
            res_reg <= '0;
        else if (cmd.commit)
            res_reg <= v_calc;
        if (cmd.out_load)
            vertical_speed_reg <= res_reg;
    end

    cvs_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    cvs_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    always_comb
    begin
        stat.div_done = div_done;
        stat.mul_done = mul_done;
        stat.tick_eq  = (tick_reg == last_tick_reg);
        stat.unseeded = (last_tick_reg == '0);
    end

    assign vertical_speed = vertical_speed_reg;

endmodule

@@ hdl/cvs_ctrl.sv @@
// Controller: sequences one transaction through the datapath and drives the handshakes.
`timescale 1ns / 1ps

module cvs_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  cvs_pkg::stat_t stat,
    output cvs_pkg::cmd_t  cmd
);

    typedef enum logic [18:0] {
        S_IDLE   = 19'b0000000000000000001,
        S_ROM_A  = 19'b0000000000000000010,
        S_ROM_B  = 19'b0000000000000000100,
        S_PS     = 19'b0000000000000001000,
        S_DIV_K  = 19'b0000000000000010000,
        S_QMUL   = 19'b0000000000000100000,
        S_PTE    = 19'b0000000000001000000,
        S_PRE    = 19'b0000000000010000000,
        S_RATE_S = 19'b0000000000100000000,
        S_DIV_R  = 19'b0000000001000000000,
        S_MULX_S = 19'b0000000010000000000,
        S_MUL_X  = 19'b0000000100000000000,
        S_MULS_S = 19'b0000001000000000000,
        S_MUL_S  = 19'b0000010000000000000,
        S_PC     = 19'b0000100000000000000,
        S_VPRE   = 19'b0001000000000000000,
        S_V_S    = 19'b0010000000000000000,
        S_DIV_V  = 19'b0100000000000000000,
        S_OUT    = 19'b1000000000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd         = '0;
        cmd.div_sel = cvs_pkg::DIV_SEL_K;
        cmd.mul_sel = cvs_pkg::MUL_SEL_X;
        state_next  = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                    state_next = S_ROM_A;
            end
            S_ROM_A:
            begin
                state_next = S_ROM_B;
            end
            S_ROM_B:
            begin
                cmd.rom_sel = 1'b1;
                cmd.ld_p0   = 1'b1;
                state_next  = S_PS;
            end
            S_PS:
            begin
                cmd.ld_ps     = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = S_DIV_K;
            end
            S_DIV_K:
            begin
                if (stat.div_done)
                begin
                    cmd.ld_k   = 1'b1;
                    state_next = S_QMUL;
                end
            end
            S_QMUL:
            begin
                cmd.ld_q   = 1'b1;
                state_next = S_PTE;
            end
            S_PTE:
            begin
                cmd.ld_pte = 1'b1;
                state_next = S_PRE;
            end
            S_PRE:
            begin
                if (stat.tick_eq)
                begin
                    cmd.res_prev = 1'b1;
                    state_next   = S_OUT;
                end
                else if (stat.unseeded)
                begin
                    cmd.seed   = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_RATE_S;
                end
            end
            S_RATE_S:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = cvs_pkg::DIV_SEL_RATE;
                state_next    = S_DIV_R;
            end
            S_DIV_R:
            begin
                if (stat.div_done)
                begin
                    cmd.ld_rate = 1'b1;
                    state_next  = S_MULX_S;
                end
            end
            S_MULX_S:
            begin
                cmd.mul_start = 1'b1;
                state_next    = S_MUL_X;
            end
            S_MUL_X:
            begin
                if (stat.mul_done)
                begin
                    cmd.ld_x   = 1'b1;
                    state_next = S_MULS_S;
                end
            end
            S_MULS_S:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = cvs_pkg::MUL_SEL_STEP;
                state_next    = S_MUL_S;
            end
            S_MUL_S:
            begin
                if (stat.mul_done)
                begin
                    cmd.ld_step = 1'b1;
                    state_next  = S_PC;
                end
            end
            S_PC:
            begin
                cmd.ld_pc  = 1'b1;
                state_next = S_VPRE;
            end
            S_VPRE:
            begin
                state_next = S_V_S;
            end
            S_V_S:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = cvs_pkg::DIV_SEL_V;
                state_next    = S_DIV_V;
            end
            S_DIV_V:
            begin
                if (stat.div_done)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

`ifndef SYNTH
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_done |-> (state_reg == S_DIV_K || state_reg == S_DIV_R ||
                           state_reg == S_DIV_V))
        else $error("divider finished outside a divide wait state");

    a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        stat.mul_done |-> (state_reg == S_MUL_X || state_reg == S_MUL_S))
        else $error("multiplier finished outside a multiply wait state");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_ROM_A))
        else $error("accepted transaction did not start the sequence");

    a_out_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid)
        else $error("output load did not raise out_valid");
`endif

endmodule

@@ hdl/capacity_vario_vertical_speed_unit.sv @@
// Top level of the capacity vario vertical speed unit.
`timescale 1ns / 1ps

// Capacity variometer: each transaction (height, true airspeed, millisecond tick)
// yields one climb rate in 1/256 m/s. From acceptance to result, a full transaction
// runs three 64-step divisions in the shared one-bit-per-cycle divider, two wide
// multiplies of four partial products each, and table, interpolation and control
// steps. A repeated tick or the first (seeding) tick skips the rate and speed
// divisions and both multiplies, but still waits for the airspeed ratio division,
// which runs before the tick is checked. One transaction is in work at a time; the
// output register lets the next one be accepted while the previous result waits.
// The atmosphere table is a ROM built at elaboration, so there is no clearing pass.
module capacity_vario_vertical_speed_unit
#(
    parameter int TABLE_POINTS = 1025,
    parameter int TICK_WIDTH   = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [15:0]           cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [13:0]           height_m,
    input  logic [10:0]           airspeed,
    input  logic [TICK_WIDTH-1:0] tick_ms,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [15:0]    vertical_speed
);

    cvs_pkg::cmd_t  cmd;
    cvs_pkg::stat_t stat;

    cvs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    cvs_datapath
    #(
        .TABLE_POINTS (TABLE_POINTS),
        .TICK_WIDTH   (TICK_WIDTH)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .height_m       (height_m),
        .airspeed       (airspeed),
        .tick_ms        (tick_ms),
        .cmd            (cmd),
        .stat           (stat),
        .vertical_speed (vertical_speed)
    );

endmodule
